### src/tmcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types, codes and constants of the text mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  RESET_COLOR = 8'h07;
    localparam logic [7:0]  BLANK_CHAR  = 8'h20;
    localparam logic [7:0]  BYTE_MASK   = 8'hFF;
    localparam logic [7:0]  CH_BS       = 8'd8;
    localparam logic [7:0]  CH_NL       = 8'd10;
    localparam logic [7:0]  CH_CR       = 8'd13;
    localparam logic [15:0] RESET_CELL  = {RESET_COLOR, BLANK_CHAR};

    typedef enum logic [2:0] {
        OP_READ,
        OP_BS,
        OP_NL,
        OP_CR,
        OP_PUT
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  char_code;
        logic [10:0] cell_address;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_COPY,
        ST_BLANK,
        ST_DONE
    } t_back_state;

    function automatic t_op classify(input logic mode, input logic [7:0] ch);
        t_op op;
        if (mode) begin
            op = OP_READ;
        end else begin
            case (ch & BYTE_MASK)
                CH_BS:   op = OP_BS;
                CH_NL:   op = OP_NL;
                CH_CR:   op = OP_CR;
                default: op = OP_PUT;
            endcase
        end
        return op;
    endfunction

endpackage

### src/tmcw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw channel interfaces
// Valid/ready channels for input items, result items and the color register.
// ----------------------------------------------------------------------------
interface tmcw_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [7:0]  char_code;
    logic [10:0] cell_address;

    modport source (output valid, mode, char_code, cell_address, input ready);
    modport sink   (input valid, mode, char_code, cell_address, output ready);
endinterface

interface tmcw_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_data;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_index;
    logic        scrolled;

    modport source (output valid, cell_data, cursor_col, cursor_row, cursor_index, scrolled,
                    input ready);
    modport sink   (input valid, cell_data, cursor_col, cursor_row, cursor_index, scrolled,
                    output ready);
endinterface

interface tmcw_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_color;

    modport source (output valid, text_color, input ready);
    modport sink   (input valid, text_color, output ready);
endinterface

### src/tmcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_front
// Accepts input transactions, classifies the byte and registers the command.
// ----------------------------------------------------------------------------
module tmcw_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tmcw_in_if.sink       i_in,
    output logic          o_push_valid,
    input  logic          i_push_ready,
    output tmcw_pkg::t_cmd o_push_cmd
);
    import tmcw_pkg::*;

    logic r_valid;
    t_cmd r_cmd;

    assign i_in.ready   = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd.op           <= classify(i_in.mode, i_in.char_code);
            r_cmd.char_code    <= i_in.char_code;
            r_cmd.cell_address <= i_in.cell_address;
        end
    end

endmodule

### src/tmcw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module tmcw_queue #(
    parameter int DEPTH = tmcw_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  tmcw_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output tmcw_pkg::t_cmd o_pop_cmd
);
    import tmcw_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_slot [DEPTH];
    logic [IDX_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [IDX_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

### src/tmcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_back
// Executes commands on the cell memory: clear pass, writes, reads, scrolling.
// ----------------------------------------------------------------------------
module tmcw_back #(
    parameter int COLUMNS = tmcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmcw_pkg::DEF_ROWS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    output logic           o_pop_ready,
    input  tmcw_pkg::t_cmd i_pop_cmd,
    input  logic [7:0]     i_text_color,
    tmcw_out_if.source     o_out
);
    import tmcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int CELL_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELLS - 1);
    localparam logic [CELL_W-1:0] COPY_END  = CELL_W'(CELLS - COLUMNS);
    localparam logic [CELL_W-1:0] ROW_STEP  = CELL_W'(COLUMNS);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [15:0]       CELLS_16  = 16'(CELLS);

    t_back_state r_state, n_state;

    logic [15:0]       r_mem [CELLS];
    logic [15:0]       r_rdata;
    logic              mem_we;
    logic [CELL_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_raddr;
    logic [15:0]       mem_wdata;

    logic [CELL_W-1:0] r_ptr, n_ptr;
    logic [CELL_W-1:0] r_wptr, n_wptr;
    logic              r_pend, n_pend;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_scrolled, n_scrolled;
    logic [15:0]       r_data, n_data;
    t_cmd              r_cmd;

    logic              r_out_valid;
    logic [15:0]       r_out_data;
    logic [6:0]        r_out_col;
    logic [4:0]        r_out_row;
    logic [10:0]       r_out_index;
    logic              r_out_scrolled;

    logic [CELL_W-1:0] row_base;
    logic [15:0]       addr_16;
    logic              addr_ok;
    logic              row_inc;
    logic              out_free;
    logic [15:0]       col_16;
    logic [15:0]       row_16;
    logic [15:0]       lin_16;

    assign row_base = CELL_W'(32'(r_row) * COLUMNS);
    assign addr_16  = 16'(r_cmd.cell_address);
    assign addr_ok  = (addr_16 < CELLS_16);
    assign out_free = !r_out_valid || o_out.ready;
    assign col_16   = 16'(r_col);
    assign row_16   = 16'(r_row);
    assign lin_16   = 16'(32'(r_row) * COLUMNS + 32'(r_col));

    assign row_inc  = (r_cmd.op == OP_NL) || ((r_cmd.op == OP_PUT) && (r_col == COL_LAST));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_ptr == LAST_CELL) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_pop_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (r_cmd.op == OP_READ) begin
                    n_state = ST_RDWAIT;
                end else if (row_inc && (r_row == ROW_LAST)) begin
                    n_state = ST_COPY;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_RDWAIT: n_state = ST_DONE;
            ST_COPY: begin
                if (r_ptr == COPY_END) n_state = ST_BLANK;
            end
            ST_BLANK: begin
                if (r_ptr == LAST_CELL) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_pop_ready = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_ptr;
        mem_wdata   = RESET_CELL;
        mem_raddr   = r_ptr;
        n_ptr       = r_ptr;
        n_wptr      = r_wptr;
        n_pend      = r_pend;
        n_col       = r_col;
        n_row       = r_row;
        n_scrolled  = r_scrolled;
        n_data      = r_data;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                n_ptr  = (r_ptr == LAST_CELL) ? '0 : r_ptr + 1'b1;
            end
            ST_IDLE: begin
                o_pop_ready = 1'b1;
                n_scrolled  = 1'b0;
                n_data      = '0;
            end
            ST_EXEC: begin
                mem_raddr = addr_16[CELL_W-1:0];
                case (r_cmd.op)
                    OP_BS: begin
                        if (r_col != '0) begin
                            n_col     = r_col - 1'b1;
                            mem_we    = 1'b1;
                            mem_waddr = row_base + CELL_W'(n_col);
                            mem_wdata = {i_text_color, BLANK_CHAR};
                        end
                    end
                    OP_NL: n_col = '0;
                    OP_CR: n_col = '0;
                    OP_PUT: begin
                        mem_we    = 1'b1;
                        mem_waddr = row_base + CELL_W'(r_col);
                        mem_wdata = {i_text_color, r_cmd.char_code};
                        n_col     = (r_col == COL_LAST) ? '0 : r_col + 1'b1;
                    end
                    default: ;
                endcase
                if (row_inc) begin
                    if (r_row == ROW_LAST) begin
                        n_scrolled = 1'b1;
                        n_ptr      = '0;
                        n_pend     = 1'b0;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            ST_RDWAIT: begin
                n_data = addr_ok ? r_rdata : '0;
            end
            ST_COPY: begin
                mem_raddr = r_ptr + ROW_STEP;
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wptr;
                    mem_wdata = r_rdata;
                end
                if (r_ptr == COPY_END) begin
                    n_pend = 1'b0;
                end else begin
                    n_pend = 1'b1;
                    n_wptr = r_ptr;
                    n_ptr  = r_ptr + 1'b1;
                end
            end
            ST_BLANK: begin
                mem_we    = 1'b1;
                mem_wdata = {i_text_color, BLANK_CHAR};
                n_ptr     = (r_ptr == LAST_CELL) ? '0 : r_ptr + 1'b1;
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_pend  <= n_pend;
            r_col   <= n_col;
            r_row   <= n_row;
            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wptr     <= n_wptr;
        r_scrolled <= n_scrolled;
        r_data     <= n_data;
        if ((r_state == ST_IDLE) && i_pop_valid) begin
            r_cmd <= i_pop_cmd;
        end
        if ((r_state == ST_DONE) && out_free) begin
            r_out_data     <= r_data;
            r_out_col      <= col_16[6:0];
            r_out_row      <= row_16[4:0];
            r_out_index    <= lin_16[10:0];
            r_out_scrolled <= r_scrolled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.cell_data    = r_out_data;
    assign o_out.cursor_col   = r_out_col;
    assign o_out.cursor_row   = r_out_row;
    assign o_out.cursor_index = r_out_index;
    assign o_out.scrolled     = r_out_scrolled;

endmodule

### src/text_mode_console_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_console_writer_core
// Character terminal engine over a ROWS x COLUMNS cell memory.
// ----------------------------------------------------------------------------
// Channels: i_in carries one transaction per character write (mode 0) or
// cell read (mode 1); o_out returns exactly one result per input, in order;
// i_cfg writes the color attribute and is always ready.
// The front registers and classifies each transaction, a two-entry queue
// holds commands, the back runs them against a single-write, single-read
// cell memory and parks the result in an output register.
// A transaction passes the front register, a queue slot, the back's IDLE,
// EXEC, RDWAIT (reads only) and DONE states, then the output register.
// The back runs one command at a time and takes the next from the queue in
// IDLE. A write that scrolls also runs through COPY and BLANK, moving the
// memory up one row and blanking the bottom row.
// Reset: a clearing pass writes grey blanks to all ROWS*COLUMNS cells (2000
// by default); inputs queue up but are not executed until it is done.
// When o_out stalls, the result holds and up to four more transactions are
// still accepted before i_in.ready drops.
// ----------------------------------------------------------------------------
module text_mode_console_writer_core #(
    parameter int COLUMNS = tmcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmcw_pkg::DEF_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tmcw_in_if.sink    i_in,
    tmcw_cfg_if.sink   i_cfg,
    tmcw_out_if.source o_out
);
    import tmcw_pkg::*;

    logic       r_text_color;
    logic [7:0] r_color;
    logic       push_valid, push_ready;
    logic       pop_valid, pop_ready;
    t_cmd       push_cmd, pop_cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color      <= RESET_COLOR;
            r_text_color <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_color      <= i_cfg.text_color;
            r_text_color <= 1'b1;
        end
    end

    tmcw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_cmd   (push_cmd)
    );

    tmcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_cmd    (pop_cmd)
    );

    tmcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (pop_valid),
        .o_pop_ready  (pop_ready),
        .i_pop_cmd    (pop_cmd),
        .i_text_color (r_text_color ? r_color : RESET_COLOR),
        .o_out        (o_out)
    );

endmodule

### src/tmcw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_checker
// Port-level checks on the result channel of the console writer.
// ----------------------------------------------------------------------------
module tmcw_checker #(
    parameter int COLUMNS = tmcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmcw_pkg::DEF_ROWS
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_cell_data,
    input logic [6:0]  i_cursor_col,
    input logic [4:0]  i_cursor_row,
    input logic [10:0] i_cursor_index,
    input logic        i_scrolled
);
    localparam bit NARROW = (COLUMNS <= 128) && (ROWS <= 32);

    logic [31:0] lin_32;
    assign lin_32 = 32'(i_cursor_row) * COLUMNS + 32'(i_cursor_col);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_cell_data) && $stable(i_cursor_index)
            && $stable(i_scrolled))
        else $error("result changed while stalled");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && NARROW |->
            (32'(i_cursor_col) < COLUMNS) && (32'(i_cursor_row) < ROWS)
            && (i_cursor_index == lin_32[10:0]))
        else $error("cursor fields inconsistent");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_scrolled && NARROW |->
            (32'(i_cursor_row) == ROWS - 1) && (i_cell_data == 16'd0))
        else $error("scroll result not on last row");

endmodule

bind text_mode_console_writer_core tmcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tmcw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_cell_data    (o_out.cell_data),
    .i_cursor_col   (o_out.cursor_col),
    .i_cursor_row   (o_out.cursor_row),
    .i_cursor_index (o_out.cursor_index),
    .i_scrolled     (o_out.scrolled)
);

### sim/text_mode_console_writer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_console_writer_core_test
// Self-checking bench for the console writer core. A queue of character
// writes and cell reads feeds a clocked driver. A clocked monitor predicts
// every accepted transaction against a local copy of the cell memory, cursor
// and color, and compares each returned result field by field, in order.
// Both channels idle in random bursts, the receiver holds off once for a
// long stretch, and the color is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module text_mode_console_writer_core_test;

    import tmcw_pkg::*;

    localparam int COLUMNS    = DEF_COLUMNS;
    localparam int ROWS       = DEF_ROWS;
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int MAX_ADDR   = 2047;
    localparam int LONG_HOLD  = 400;
    localparam int HOLD_AT    = 120;
    localparam int SETTLE     = 16;
    localparam int PHASES     = 5;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  char_code;
        logic [10:0] cell_address;
    } t_req;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_index;
        logic        scrolled;
    } t_cursor_result;

    logic i_clk;
    logic i_rst_n;

    tmcw_in_if  in_ch();
    tmcw_out_if out_ch();
    tmcw_cfg_if cfg_ch();

    text_mode_console_writer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // screen model
    logic [15:0] screen_mem [0:CELLS-1];
    int unsigned cur_row;
    int unsigned cur_col;
    logic [7:0]  attr;

    t_req           req_queue  [$];
    t_cursor_result cursor_q   [$];

    logic        in_accepted;
    logic        quiet;
    int unsigned send_gap;
    int unsigned hold_left;
    logic        long_hold_done;
    int unsigned results_seen;
    int unsigned fail_count;
    int unsigned color_writes;
    int unsigned write_count;
    int unsigned read_count;
    int unsigned scroll_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("text_mode_console_writer_core_test failed");
        $finish;
    end

    function automatic t_cursor_result console_step(input t_req req);
        t_cursor_result res;
        int unsigned k;
        res = '0;
        if (req.mode == MODE_READ) begin
            if (req.cell_address < CELLS) begin
                res.cell_data = screen_mem[req.cell_address];
            end
        end else begin
            case (req.char_code)
                CH_BS: begin
                    if (cur_col > 0) begin
                        cur_col = cur_col - 1;
                        screen_mem[cur_row * COLUMNS + cur_col] = {attr, BLANK_CHAR};
                    end
                end
                CH_NL: begin
                    cur_row = cur_row + 1;
                    cur_col = 0;
                end
                CH_CR: begin
                    cur_col = 0;
                end
                default: begin
                    screen_mem[cur_row * COLUMNS + cur_col] = {attr, req.char_code};
                    cur_col = cur_col + 1;
                end
            endcase
            if (cur_col >= COLUMNS) begin
                cur_col = 0;
                cur_row = cur_row + 1;
            end
            if (cur_row >= ROWS) begin
                for (k = 0; k + COLUMNS < CELLS; k++) begin
                    screen_mem[k] = screen_mem[k + COLUMNS];
                end
                for (k = CELLS - COLUMNS; k < CELLS; k++) begin
                    screen_mem[k] = {attr, BLANK_CHAR};
                end
                cur_row = ROWS - 1;
                res.scrolled = 1'b1;
                scroll_count++;
            end
        end
        res.cursor_col   = 7'(cur_col);
        res.cursor_row   = 5'(cur_row);
        res.cursor_index = 11'(cur_row * COLUMNS + cur_col);
        return res;
    endfunction

    function automatic t_req random_request(input int unsigned newline_pct);
        t_req req;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        req.mode = MODE_WRITE;
        req.cell_address = 11'($urandom_range(0, MAX_ADDR));
        if (pick < 25) begin
            req.mode = MODE_READ;
            req.char_code = 8'($urandom);
            if ($urandom_range(0, 9) == 0) begin
                req.cell_address = 11'($urandom_range(CELLS, MAX_ADDR));
            end else begin
                req.cell_address = 11'($urandom_range(0, CELLS - 1));
            end
        end else if (pick < 25 + newline_pct) begin
            req.char_code = CH_NL;
        end else if (pick < 28 + newline_pct) begin
            req.char_code = CH_CR;
        end else if (pick < 33 + newline_pct) begin
            req.char_code = CH_BS;
        end else if ($urandom_range(0, 3) == 0) begin
            req.char_code = 8'($urandom_range(0, 255));
        end else begin
            req.char_code = 8'($urandom_range(8'h20, 8'h7E));
        end
        return req;
    endfunction

    task automatic queue_request(input logic mode, input logic [7:0] ch,
                                 input logic [10:0] addr);
        req_queue.push_back('{mode, ch, addr});
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (req_queue.size() != 0 || in_ch.valid || cursor_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_color(input logic [7:0] color);
        int unsigned seen;
        seen = color_writes;
        @(negedge i_clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.text_color <= color;
        wait (color_writes != seen);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        t_req req;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_accepted) begin
            if (send_gap > 0) begin
                send_gap    <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (req_queue.size() == 0) begin
                in_ch.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                send_gap    <= $urandom_range(0, 5);
                in_ch.valid <= 1'b0;
            end else begin
                req = req_queue.pop_front();
                in_ch.valid        <= 1'b1;
                in_ch.mode         <= req.mode;
                in_ch.char_code    <= req.char_code;
                in_ch.cell_address <= req.cell_address;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= HOLD_AT) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD - 1;
            out_ch.ready   <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            hold_left    <= $urandom_range(0, 5);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_cursor_result got;
        t_cursor_result want;
        t_req req;
        in_accepted <= in_ch.valid && in_ch.ready;
        if (out_ch.valid && out_ch.ready) begin
            got = '{out_ch.cell_data, out_ch.cursor_col, out_ch.cursor_row,
                    out_ch.cursor_index, out_ch.scrolled};
            results_seen <= results_seen + 1;
            if (cursor_q.size() == 0) begin
                $error("result transaction with no pending expectation");
                fail_count++;
            end else begin
                want = cursor_q.pop_front();
                compare_field("cell_data", want.cell_data, got.cell_data);
                compare_field("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
                compare_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
                compare_field("cursor_index", 16'(want.cursor_index),
                              16'(got.cursor_index));
                compare_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
            end
        end
        if (in_ch.valid && in_ch.ready) begin
            req = '{in_ch.mode, in_ch.char_code, in_ch.cell_address};
            cursor_q.push_back(console_step(req));
            if (req.mode == MODE_READ) begin
                read_count++;
            end else begin
                write_count++;
            end
        end
        if (cfg_ch.valid && cfg_ch.ready) begin
            attr = cfg_ch.text_color;
            color_writes++;
        end
    end

    initial begin
        logic [7:0]  phase_color [PHASES];
        int unsigned phase_items [PHASES];
        int unsigned phase_nl    [PHASES];
        int unsigned p;
        int unsigned n;

        phase_color = '{8'hFF, 8'h00, 8'h1E, 8'($urandom), 8'($urandom)};
        phase_items = '{350, 300, 350, 300, 300};
        phase_nl    = '{5, 0, 5, 8, 4};

        for (n = 0; n < CELLS; n++) begin
            screen_mem[n] = RESET_CELL;
        end
        cur_row = 0;
        cur_col = 0;
        attr    = RESET_COLOR;

        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.mode         = MODE_WRITE;
        in_ch.char_code    = '0;
        in_ch.cell_address = '0;
        out_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.text_color  = '0;
        in_accepted        = 1'b0;
        quiet              = 1'b0;
        send_gap           = 0;
        hold_left          = 0;
        long_hold_done     = 1'b0;
        results_seen       = 0;
        fail_count         = 0;
        color_writes       = 0;
        write_count        = 0;
        read_count         = 0;
        scroll_count       = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, backspace at and past column zero,
        // ignored fields, out-of-range reads
        queue_request(MODE_WRITE, 8'h41, 11'd2047);
        queue_request(MODE_WRITE, 8'hFF, 11'd0);
        queue_request(MODE_WRITE, 8'h00, 11'h555);
        queue_request(MODE_WRITE, 8'h80, 11'h2AA);
        queue_request(MODE_WRITE, CH_BS, 11'd0);
        queue_request(MODE_READ, 8'hFF, 11'd0);
        queue_request(MODE_READ, 8'h00, 11'd3);
        queue_request(MODE_WRITE, CH_CR, 11'd0);
        queue_request(MODE_WRITE, CH_BS, 11'd0);
        queue_request(MODE_WRITE, 8'h7F, 11'd0);
        queue_request(MODE_WRITE, CH_NL, 11'd0);
        queue_request(MODE_WRITE, 8'h55, 11'd0);
        queue_request(MODE_READ, 8'h00, 11'd80);
        queue_request(MODE_READ, 8'h00, 11'd1999);
        queue_request(MODE_READ, 8'h00, 11'd2000);
        queue_request(MODE_READ, 8'hFF, 11'd2047);
        queue_request(MODE_READ, 8'hAA, 11'h555);
        queue_request(MODE_READ, 8'h55, 11'h2AA);
        queue_request(MODE_READ, 8'h00, 11'd1);
        wait_drained();

        for (p = 0; p < PHASES; p++) begin
            set_color(phase_color[p]);
            if (p == PHASES - 1) begin
                quiet = 1'b1;
            end
            for (n = 0; n < phase_items[p]; n++) begin
                req_queue.push_back(random_request(phase_nl[p]));
            end
            wait_drained();
        end

        $display("Ran %0d transactions: %0d character writes, %0d cell reads, %0d scrolls,",
                 write_count + read_count, write_count, read_count, scroll_count);
        $display("%0d color settings, one long receiver hold-off.", color_writes);
        if (fail_count == 0) begin
            $display("text_mode_console_writer_core_test passed");
        end else begin
            $display("text_mode_console_writer_core_test failed");
        end
        $finish;
    end

endmodule

### sim.f
src/tmcw_pkg.sv
src/tmcw_if.sv
src/tmcw_front.sv
src/tmcw_queue.sv
src/tmcw_back.sv
src/text_mode_console_writer_core.sv
src/tmcw_checker.sv
sim/text_mode_console_writer_core_test.sv
